// ===== src/plp_pkg.sv =====
// ----------------------------------------------------------------------------
// plp_pkg: shared types and constants for the prefixed literal byte parser
// Parse phases, base codes and the per-character digit decode.
// ----------------------------------------------------------------------------
package plp_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'b001,
    PH_ZERO   = 3'b010,
    PH_DIGITS = 3'b100
  } phase_t;

  typedef logic [1:0] radix_t;

  localparam radix_t RAD_BIN = 2'd0;
  localparam radix_t RAD_OCT = 2'd1;
  localparam radix_t RAD_DEC = 2'd2;
  localparam radix_t RAD_HEX = 2'd3;

  localparam logic [7:0] CHR_0  = 8'h30;
  localparam logic [7:0] CHR_9  = 8'h39;
  localparam logic [7:0] CHR_LA = 8'h61;
  localparam logic [7:0] CHR_LF = 8'h66;
  localparam logic [7:0] CHR_UA = 8'h41;
  localparam logic [7:0] CHR_UF = 8'h46;
  localparam logic [7:0] CHR_LB = 8'h62;
  localparam logic [7:0] CHR_UB = 8'h42;
  localparam logic [7:0] CHR_LO = 8'h6f;
  localparam logic [7:0] CHR_UO = 8'h4f;
  localparam logic [7:0] CHR_LX = 8'h78;
  localparam logic [7:0] CHR_UX = 8'h58;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Decode one character as a digit of the given base.
  function automatic digit_t digit_of(input logic [7:0] c, input radix_t rad);
    digit_t     d;
    logic [7:0] diff;
    d    = '{ok: 1'b0, val: 4'd0};
    diff = 8'd0;
    if (c >= CHR_0 && c <= CHR_9) begin
      diff = c - CHR_0;
      d    = '{ok: 1'b1, val: diff[3:0]};
    end else if (rad == RAD_HEX && c >= CHR_LA && c <= CHR_LF) begin
      diff = c - CHR_LA + 8'd10;
      d    = '{ok: 1'b1, val: diff[3:0]};
    end else if (rad == RAD_HEX && c >= CHR_UA && c <= CHR_UF) begin
      diff = c - CHR_UA + 8'd10;
      d    = '{ok: 1'b1, val: diff[3:0]};
    end
    if (rad == RAD_BIN && d.val > 4'd1) d.ok = 1'b0;
    if (rad == RAD_OCT && d.val > 4'd7) d.ok = 1'b0;
    return d;
  endfunction

  // acc * base + digit, modulo 256, using shifts and adds only.
  function automatic logic [7:0] mac_digit(input logic [7:0] acc, input radix_t rad,
                                           input logic [3:0] dv);
    logic [7:0] scaled;
    unique case (rad)
      RAD_BIN: scaled = {acc[6:0], 1'b0};
      RAD_OCT: scaled = {acc[4:0], 3'b000};
      RAD_HEX: scaled = {acc[3:0], 4'b0000};
      default: scaled = {acc[4:0], 3'b000} + {acc[6:0], 1'b0};
    endcase
    return scaled + {4'd0, dv};
  endfunction

endpackage

// ===== src/prefixed_literal_byte_parser_unit.sv =====
// ----------------------------------------------------------------------------
// prefixed_literal_byte_parser_unit: streaming integer literal parser
// Parses binary, octal, hex (prefixed) and decimal literals into a byte.
// ----------------------------------------------------------------------------
// The final character is held in the input register, then its result in the
// result register. One character enters per cycle unless a final character
// waits on a full, stalled result register; a new one still enters while a
// result waits. Reset (rst_n low, synchronous) empties both registers and
// returns the parse state to the start of a literal in decimal.
module prefixed_literal_byte_parser_unit
  import plp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] byte_value
  output logic [2:0] out_tuser   // [0] parse_status, [2:1] base_found
);

  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       s1_adv;

  phase_t     phase_r, phase_nxt;
  radix_t     rad_r, rad_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       bad_r, bad_nxt;
  logic       dig_r, dig_nxt;

  logic       out_v_r, out_v_nxt;
  logic [7:0] out_data_r;
  logic [2:0] out_user_r;
  logic       load_out;

  radix_t     use_rad;
  digit_t     dg;
  logic       is_b, is_o, is_x, ok;
  logic [7:0] upd_acc;
  logic       upd_bad, upd_dig;

  // The input stage only stalls when it holds a final character and the
  // result register cannot take it.
  assign s1_adv    = !s1_last_r || !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign load_out  = s1_v_r && s1_last_r && s1_adv;

  assign s1_v_nxt  = (in_tvalid && in_tready) ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  always_comb begin
    is_b = (s1_char_r == CHR_LB) || (s1_char_r == CHR_UB);
    is_o = (s1_char_r == CHR_LO) || (s1_char_r == CHR_UO);
    is_x = (s1_char_r == CHR_LX) || (s1_char_r == CHR_UX);

    use_rad = (phase_r == PH_START) ? RAD_DEC : rad_r;
    dg      = digit_of(s1_char_r, use_rad);
    upd_acc = dg.ok ? mac_digit(acc_r, use_rad, dg.val) : acc_r;
    upd_dig = dg.ok ? 1'b1 : dig_r;
    upd_bad = dg.ok ? bad_r : 1'b1;

    phase_nxt = PH_DIGITS;
    rad_nxt   = use_rad;
    acc_nxt   = upd_acc;
    bad_nxt   = upd_bad;
    dig_nxt   = upd_dig;

    unique case (phase_r)
      PH_START: begin
        phase_nxt = (s1_char_r == CHR_0) ? PH_ZERO : PH_DIGITS;
      end
      PH_ZERO: begin
        if (is_b || is_o || is_x) begin
          rad_nxt = is_b ? RAD_BIN : (is_o ? RAD_OCT : RAD_HEX);
          acc_nxt = 8'd0;
          dig_nxt = 1'b0;
          bad_nxt = bad_r;
        end
      end
      default: begin
      end
    endcase

    ok = !bad_nxt && dig_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= PH_START;
      rad_r   <= RAD_DEC;
      acc_r   <= 8'd0;
      bad_r   <= 1'b0;
      dig_r   <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_v_r && s1_adv) begin
        if (s1_last_r) begin
          // end of literal: back to the start state
          phase_r <= PH_START;
          rad_r   <= RAD_DEC;
          acc_r   <= 8'd0;
          bad_r   <= 1'b0;
          dig_r   <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          rad_r   <= rad_nxt;
          acc_r   <= acc_nxt;
          bad_r   <= bad_nxt;
          dig_r   <= dig_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (load_out) begin
      out_data_r <= ok ? acc_nxt : 8'd0;
      out_user_r <= {rad_nxt, !ok};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== src/plp_checker.sv =====
// ----------------------------------------------------------------------------
// plp_checker: port-level checks for the literal parser
// Watches handshakes and result fields of the parser's ports.
// ----------------------------------------------------------------------------
module plp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 8'd0)
    else $error("invalid literal with nonzero value");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a final character");

endmodule

bind prefixed_literal_byte_parser_unit plp_checker u_plp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/prefixed_literal_byte_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// prefixed_literal_byte_parser_unit_tb: self-checking bench for the literal parser
// Streams ASCII literals (binary, octal, hex, decimal, malformed and noise)
// through the input channel with bursty traffic. Each result is checked against
// an in-bench parser model while the output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module prefixed_literal_byte_parser_unit_tb;
  import plp_pkg::*;

  localparam int CHAR_TARGET = 2000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       parse_status;
    radix_t     base_found;
  } parse_result_t;

  typedef struct {
    logic [31:0] text;     // characters right-justified, first one highest
    int          len;
    bit          known;    // expected result typed in below
    logic [7:0]  value;
    logic        status;
    radix_t      base;
  } literal_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;

  // Parser model state
  phase_t     lit_phase;
  radix_t     lit_radix;
  logic [7:0] lit_acc;
  logic       lit_bad;
  logic       lit_digit;

  parse_result_t expected_results[$];
  literal_row_t  directed_rows[11];

  int  burst_left;
  int  chars_sent;
  int  literals_sent;
  int  results_seen;
  int  valid_results;
  int  base_hits[4];
  int  mismatches;
  int  cycle_count;
  bit  hold_armed;

  prefixed_literal_byte_parser_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Digit value of c in base r, or 16 when c is no such digit.
  function automatic int digit_value(input logic [7:0] c, input radix_t r);
    int d;
    d = 16;
    if (c >= "0" && c <= "9") d = int'(c) - int'("0");
    else if (r == RAD_HEX && c >= "a" && c <= "f") d = int'(c) - int'("a") + 10;
    else if (r == RAD_HEX && c >= "A" && c <= "F") d = int'(c) - int'("A") + 10;
    if (r == RAD_BIN && d > 1) d = 16;
    if (r == RAD_OCT && d > 7) d = 16;
    return d;
  endfunction

  function automatic void clear_literal();
    lit_phase = PH_START;
    lit_radix = RAD_DEC;
    lit_acc   = 8'd0;
    lit_bad   = 1'b0;
    lit_digit = 1'b0;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    int d;
    int mult;
    int sum;
    d = digit_value(c, lit_radix);
    case (lit_radix)
      RAD_BIN: mult = 2;
      RAD_OCT: mult = 8;
      RAD_HEX: mult = 16;
      default: mult = 10;
    endcase
    if (d < 16) begin
      sum       = lit_acc * mult + d;
      lit_acc   = sum[7:0];
      lit_digit = 1'b1;
    end else begin
      lit_bad = 1'b1;
    end
  endfunction

  // Advance the model by one character; returns 1 when a result is due.
  function automatic bit advance_literal(input logic [7:0] c, input logic last,
                                         output parse_result_t res);
    bit ok;
    res = '0;
    if (lit_phase == PH_START) begin
      lit_radix = RAD_DEC;
      take_digit(c);
      lit_phase = (c == "0") ? PH_ZERO : PH_DIGITS;
    end else if (lit_phase == PH_ZERO) begin
      lit_phase = PH_DIGITS;
      if (c == "b" || c == "B") lit_radix = RAD_BIN;
      else if (c == "o" || c == "O") lit_radix = RAD_OCT;
      else if (c == "x" || c == "X") lit_radix = RAD_HEX;
      else take_digit(c);
      // restart the value after a prefix
      if (lit_radix != RAD_DEC) begin
        lit_acc   = 8'd0;
        lit_digit = 1'b0;
      end
    end else begin
      take_digit(c);
    end
    if (!last) return 1'b0;
    ok               = !lit_bad && lit_digit;
    res.byte_value   = ok ? lit_acc : 8'd0;
    res.parse_status = !ok;
    res.base_found   = lit_radix;
    clear_literal();
    return 1'b1;
  endfunction

  function automatic logic [7:0] prefix_char(input radix_t r);
    logic [7:0] p;
    case (r)
      RAD_BIN: p = "b";
      RAD_OCT: p = "o";
      default: p = "x";
    endcase
    if ($urandom_range(0, 1)) p = p - 8'h20;
    return p;
  endfunction

  function automatic logic [7:0] digit_char(input radix_t r);
    int d;
    case (r)
      RAD_BIN: d = $urandom_range(0, 1);
      RAD_OCT: d = $urandom_range(0, 7);
      RAD_HEX: d = $urandom_range(0, 15);
      default: d = $urandom_range(0, 9);
    endcase
    if (d < 10) return 8'("0" + d);
    return $urandom_range(0, 1) ? 8'("a" + d - 10) : 8'("A" + d - 10);
  endfunction

  // Offer one character, hold it until the transaction completes, then predict.
  task automatic offer_char(input logic [7:0] c, input logic last);
    int            gap;
    parse_result_t res;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    chars_sent++;
    if (advance_literal(c, last, res)) begin
      literals_sent++;
      expected_results.push_back(res);
    end
  endtask

  task automatic offer_random_literal();
    logic [7:0] text[$];
    logic [7:0] bad;
    int         kind;
    int         n;
    int         pos;
    radix_t     r;
    kind = $urandom_range(0, 99);
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    r    = radix_t'($urandom_range(0, 3));
    if (kind < 85) begin
      if (r != RAD_DEC) begin
        text.push_back("0");
        text.push_back(prefix_char(r));
      end
      pos = text.size() + $urandom_range(0, n - 1);
      repeat (n) text.push_back(digit_char(r));
      // break one digit of a well-formed literal
      if (kind >= 75) begin
        do bad = 8'($urandom_range(0, 255)); while (digit_value(bad, r) != 16);
        text[pos] = bad;
      end
    end else if (kind < 92) begin
      text.push_back("0");
      if (kind < 88) text.push_back(prefix_char(r));
      else text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (n) text.push_back(8'($urandom_range(0, 255)));
    end
    foreach (text[i]) offer_char(text[i], i == text.size() - 1);
  endtask

  // Stimulus
  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'd0;
    in_tlast   <= 1'b0;
    hold_armed <= 1'b0;
    burst_left = 0;
    clear_literal();
    directed_rows = '{
      '{"0",    1, 1'b1, 8'd0,   1'b0, RAD_DEC},
      '{"0b",   2, 1'b1, 8'd0,   1'b1, RAD_BIN},
      '{"0B1",  3, 1'b1, 8'd1,   1'b0, RAD_BIN},
      '{"0o7",  3, 1'b1, 8'd7,   1'b0, RAD_OCT},
      '{"0XfF", 4, 1'b1, 8'd255, 1'b0, RAD_HEX},
      '{"256",  3, 1'b0, 8'd0,   1'b0, RAD_DEC},
      '{32'hFF, 1, 1'b1, 8'd0,   1'b1, RAD_DEC},
      '{32'h00, 1, 1'b1, 8'd0,   1'b1, RAD_DEC},
      '{"0O8",  3, 1'b1, 8'd0,   1'b1, RAD_OCT},
      '{"1x",   2, 1'b1, 8'd0,   1'b1, RAD_DEC},
      '{"09",   2, 1'b1, 8'd9,   1'b0, RAD_DEC}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].len; i++) begin
        offer_char(directed_rows[r].text[8*(directed_rows[r].len-1-i) +: 8],
                   i == directed_rows[r].len - 1);
      end
      // replace the prediction with the hand-written result
      if (directed_rows[r].known) begin
        expected_results[$] = '{directed_rows[r].value, directed_rows[r].status,
                                directed_rows[r].base};
      end
    end

    while (chars_sent < CHAR_TARGET) begin
      if (literals_sent == 80) hold_armed <= 1'b1;
      offer_random_literal();
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d characters in %0d literals; %0d results checked, %0d valid.",
             chars_sent, literals_sent, results_seen, valid_results);
    $display("Results by base: bin %0d, oct %0d, dec %0d, hex %0d.",
             base_hits[RAD_BIN], base_hits[RAD_OCT], base_hits[RAD_DEC], base_hits[RAD_HEX]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Output side: rotate through stall styles, plus one long hold
  initial begin
    int  style;
    int  style_left;
    int  hold_left;
    int  tick;
    bit  hold_done;
    style      = 0;
    style_left = 0;
    hold_left  = 0;
    tick       = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(20, 120);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (!out_tuser[0]) valid_results++;
      base_hits[out_tuser[2:1]]++;
      if (expected_results.size() == 0) begin
        $error("result with no literal pending: byte_value %0d", out_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want.byte_value) begin
          $error("byte_value expected %0d got %0d", want.byte_value, out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== want.parse_status) begin
          $error("parse_status expected %0d got %0d", want.parse_status, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[2:1] !== want.base_found) begin
          $error("base_found expected %0d got %0d", want.base_found, out_tuser[2:1]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
